/* rtl/bitmap_block_pool_allocator_macros.svh */
// Assertion helpers shared by the allocator RTL.
`ifndef BITMAP_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bbpa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bbpa assertion failed");

`endif

/* rtl/bbpa_pkg.sv */
`timescale 1ns / 1ps

package bbpa_pkg;

	localparam int unsigned OFF_W     = 16;
	localparam int unsigned SIZE_W    = 11;
	localparam int unsigned COUNT_W   = 7;
	localparam int unsigned IDX_OUT_W = 6;
	localparam int unsigned CTR_W     = 32;
	localparam int unsigned STEP_W    = $clog2(OFF_W + 1);

	// health thresholds, percent
	localparam int unsigned PCT_SCALE       = 100;
	localparam int unsigned HEALTH_WARN_PCT = 80;
	localparam int unsigned HEALTH_CRIT_PCT = 95;
	localparam int unsigned PCT_W           = 14;

	// opcodes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_STATS = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_INVALID = 2'd2;
	localparam logic [1:0] STAT_DOUBLE  = 2'd3;

	// health classes
	localparam logic [1:0] HEALTH_GOOD = 2'd0;
	localparam logic [1:0] HEALTH_WARN = 2'd1;
	localparam logic [1:0] HEALTH_CRIT = 2'd2;

	// config register indexes
	localparam logic CFG_BLOCK_COUNT = 1'b0;
	localparam logic CFG_BLOCK_SIZE  = 1'b1;

	typedef struct packed {
		logic              start;
		logic [OFF_W-1:0]  dividend;
		logic [SIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [OFF_W-1:0]  quot;
		logic [SIZE_W-1:0] rem;
	} div_rsp_t;

endpackage

/* rtl/bbpa_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module bbpa_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bbpa_pkg::div_req_t req,
	output bbpa_pkg::div_rsp_t rsp
);

	logic [bbpa_pkg::OFF_W-1:0]  quo_q;
	logic [bbpa_pkg::SIZE_W-1:0] rem_q;
	logic [bbpa_pkg::SIZE_W-1:0] dvs_q;
	logic [bbpa_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;

	logic [bbpa_pkg::SIZE_W:0]   trial;
	logic                        fits;
	logic [bbpa_pkg::SIZE_W:0]   diff;

	assign trial = {rem_q, quo_q[bbpa_pkg::OFF_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= bbpa_pkg::STEP_W'(bbpa_pkg::OFF_W);
			end else if (busy_q) begin
				step_q <= step_q - bbpa_pkg::STEP_W'(1);
				if (step_q == bbpa_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bbpa_pkg::OFF_W-2:0], fits};
			rem_q <= fits ? diff[bbpa_pkg::SIZE_W-1:0] : trial[bbpa_pkg::SIZE_W-1:0];
		end
	end

	assign rsp = {done_q, quo_q, rem_q};

endmodule

/* rtl/bitmap_block_pool_allocator.sv */
`timescale 1ns / 1ps

// Fixed-block pool allocator, free bitmap, next-fit search.
// Request channel (in_valid/in_ready) carries opcode and byte_offset: allocate,
// free, or clear statistics. Each request yields exactly one result word on the
// out channel (out_valid/out_ready): status, slot index/offset, usage counters
// and a health class (warning at 80 percent, critical at 95 percent used).
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the pool size
// in blocks (index 0) and the bytes per block (index 1); always ready, write
// only while idle.
// One request is in flight at a time; in_ready is high only in the idle state.
// Steps from the accepting edge to the edge that raises out_valid:
//   allocate: the scan state probes n slots (1..pool size), one bitmap bit per
//             cycle by the scan sequencer, then the multiply state forms the
//             offset; a failed scan skips it, a pool full up front skips both.
//   free:     the 16-step shared divider for offset / size, then done.
//   stats or unused opcode: straight to the done state.
// A finished word sits in the output register; a new request may be taken
// while it waits. If the receiver stalls, the next result holds in the final
// state until the output register empties.
// Reset: every block free, hint and all counters zero, 64 blocks of 32 bytes.
module bitmap_block_pool_allocator #(
	parameter int MAX_BLOCKS     = 64,
	parameter int MAX_BLOCK_SIZE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] byte_offset,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [5:0]  slot_index,
	output logic [15:0] block_offset,
	output logic [6:0]  used_now,
	output logic [6:0]  used_peak,
	output logic [31:0] alloc_total,
	output logic [31:0] free_total,
	output logic [31:0] fail_total,
	output logic [1:0]  health,
	// config channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	`include "bitmap_block_pool_allocator_macros.svh"

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int MUL_W = IDX_W + bbpa_pkg::SIZE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t state_q;

	// config registers
	logic [bbpa_pkg::COUNT_W-1:0] count_q;
	logic [bbpa_pkg::SIZE_W-1:0]  size_q;

	// pool state
	logic [MAX_BLOCKS-1:0]      free_map_q;
	logic [IDX_W-1:0]           hint_q;
	logic [CNT_W-1:0]           used_q;
	logic [CNT_W-1:0]           peak_q;
	logic [bbpa_pkg::CTR_W-1:0] alloc_q;
	logic [bbpa_pkg::CTR_W-1:0] free_q;
	logic [bbpa_pkg::CTR_W-1:0] fail_q;

	// per-request working registers
	logic [bbpa_pkg::OFF_W-1:0] off_q;
	logic [IDX_W-1:0]           scan_k_q;
	logic [CNT_W-1:0]           scan_n_q;
	logic [1:0]                 res_status_q;
	logic [IDX_W-1:0]           res_idx_q;
	logic [bbpa_pkg::OFF_W-1:0] res_boff_q;

	// output register
	logic                         out_valid_q;
	logic [1:0]                   status_q;
	logic [IDX_W-1:0]             index_q;
	logic [bbpa_pkg::OFF_W-1:0]   boff_q;
	logic [CNT_W-1:0]             used_out_q;
	logic [CNT_W-1:0]             peak_out_q;
	logic [bbpa_pkg::CTR_W-1:0]   alloc_out_q;
	logic [bbpa_pkg::CTR_W-1:0]   free_out_q;
	logic [bbpa_pkg::CTR_W-1:0]   fail_out_q;
	logic [1:0]                   health_q;

	// effective (clamped) config
	logic [CNT_W-1:0]             cnt_eff;
	logic [bbpa_pkg::SIZE_W-1:0]  sz_eff;

	always_comb begin
		if (count_q == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (32'(count_q) > 32'(MAX_BLOCKS)) begin
			cnt_eff = CNT_W'(MAX_BLOCKS);
		end else begin
			cnt_eff = CNT_W'(count_q);
		end
	end

	always_comb begin
		if (size_q == '0) begin
			sz_eff = bbpa_pkg::SIZE_W'(1);
		end else if (32'(size_q) > 32'(MAX_BLOCK_SIZE)) begin
			sz_eff = bbpa_pkg::SIZE_W'(MAX_BLOCK_SIZE);
		end else begin
			sz_eff = size_q;
		end
	end

	// handshakes
	logic in_fire;
	logic out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// shared divider: offset / block size
	bbpa_pkg::div_req_t div_req;
	bbpa_pkg::div_rsp_t div_rsp;

	assign div_req = {in_fire && (opcode == bbpa_pkg::OP_FREE), byte_offset, sz_eff};

	bbpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// scan helpers
	logic [IDX_W-1:0] scan_start;
	logic [IDX_W-1:0] scan_next;
	logic             scan_last;

	assign scan_start = (CNT_W'(hint_q) < cnt_eff) ? hint_q : '0;
	assign scan_next  = ((CNT_W'(scan_k_q) + CNT_W'(1)) == cnt_eff) ? '0
	                  : scan_k_q + IDX_W'(1);
	assign scan_last  = (scan_n_q == (cnt_eff - CNT_W'(1)));

	// free checks on divider result
	logic             div_bad;
	logic [IDX_W-1:0] div_idx;

	assign div_bad = (div_rsp.quot >= bbpa_pkg::OFF_W'(cnt_eff)) || (div_rsp.rem != '0);
	assign div_idx = div_rsp.quot[IDX_W-1:0];

	// block offset of an allocated block
	logic [MUL_W-1:0] mul_p;

	assign mul_p = MUL_W'(res_idx_q) * MUL_W'(sz_eff);

	// health: util >= pct  <=>  used*100 >= pct*count
	logic [bbpa_pkg::PCT_W-1:0] used_x100;
	logic [bbpa_pkg::PCT_W-1:0] warn_lim;
	logic [bbpa_pkg::PCT_W-1:0] crit_lim;
	logic [1:0]                 health_d;

	assign used_x100 = bbpa_pkg::PCT_W'(used_q) * bbpa_pkg::PCT_W'(bbpa_pkg::PCT_SCALE);
	assign warn_lim  = bbpa_pkg::PCT_W'(cnt_eff) * bbpa_pkg::PCT_W'(bbpa_pkg::HEALTH_WARN_PCT);
	assign crit_lim  = bbpa_pkg::PCT_W'(cnt_eff) * bbpa_pkg::PCT_W'(bbpa_pkg::HEALTH_CRIT_PCT);
	assign health_d  = (used_x100 >= crit_lim) ? bbpa_pkg::HEALTH_CRIT
	                 : (used_x100 >= warn_lim) ? bbpa_pkg::HEALTH_WARN
	                 : bbpa_pkg::HEALTH_GOOD;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= bbpa_pkg::COUNT_W'(64);
			size_q  <= bbpa_pkg::SIZE_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bbpa_pkg::CFG_BLOCK_COUNT: count_q <= cfg_data[bbpa_pkg::COUNT_W-1:0];
				bbpa_pkg::CFG_BLOCK_SIZE:  size_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, pool state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			free_map_q   <= '1;
			hint_q       <= '0;
			used_q       <= '0;
			peak_q       <= '0;
			alloc_q      <= '0;
			free_q       <= '0;
			fail_q       <= '0;
			off_q        <= '0;
			scan_k_q     <= '0;
			scan_n_q     <= '0;
			res_status_q <= bbpa_pkg::STAT_OK;
			res_idx_q    <= '0;
			res_boff_q   <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= bbpa_pkg::STAT_OK;
			index_q      <= '0;
			boff_q       <= '0;
			used_out_q   <= '0;
			peak_out_q   <= '0;
			alloc_out_q  <= '0;
			free_out_q   <= '0;
			fail_out_q   <= '0;
			health_q     <= bbpa_pkg::HEALTH_GOOD;
		end else begin
			// a new word loads in the done state; otherwise an accepted word drops
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_idx_q  <= '0;
						res_boff_q <= '0;
						off_q      <= byte_offset;
						case (opcode)
							bbpa_pkg::OP_ALLOC: begin
								if (used_q >= cnt_eff) begin
									res_status_q <= bbpa_pkg::STAT_FULL;
									fail_q       <= fail_q + bbpa_pkg::CTR_W'(1);
									state_q      <= ST_DONE;
								end else begin
									res_status_q <= bbpa_pkg::STAT_OK;
									scan_k_q     <= scan_start;
									scan_n_q     <= '0;
									state_q      <= ST_SCAN;
								end
							end
							bbpa_pkg::OP_FREE: begin
								res_status_q <= bbpa_pkg::STAT_OK;
								state_q      <= ST_DIV;
							end
							bbpa_pkg::OP_STATS: begin
								res_status_q <= bbpa_pkg::STAT_OK;
								alloc_q      <= '0;
								free_q       <= '0;
								fail_q       <= '0;
								peak_q       <= used_q;
								state_q      <= ST_DONE;
							end
							default: begin
								res_status_q <= bbpa_pkg::STAT_OK;
								state_q      <= ST_DONE;
							end
						endcase
					end
				end

				ST_SCAN: begin
					if (free_map_q[scan_k_q]) begin
						free_map_q[scan_k_q] <= 1'b0;
						used_q    <= used_q + CNT_W'(1);
						alloc_q   <= alloc_q + bbpa_pkg::CTR_W'(1);
						if ((used_q + CNT_W'(1)) > peak_q) begin
							peak_q <= used_q + CNT_W'(1);
						end
						hint_q    <= scan_next;
						res_idx_q <= scan_k_q;
						state_q   <= ST_MUL;
					end else if (scan_last) begin
						res_status_q <= bbpa_pkg::STAT_FULL;
						fail_q       <= fail_q + bbpa_pkg::CTR_W'(1);
						state_q      <= ST_DONE;
					end else begin
						scan_k_q <= scan_next;
						scan_n_q <= scan_n_q + CNT_W'(1);
					end
				end

				ST_DIV: begin
					if (div_rsp.done) begin
						if (div_bad) begin
							res_status_q <= bbpa_pkg::STAT_INVALID;
						end else begin
							res_idx_q  <= div_idx;
							// remainder is zero, so index * size is the offset itself
							res_boff_q <= off_q;
							if (free_map_q[div_idx]) begin
								res_status_q <= bbpa_pkg::STAT_DOUBLE;
							end else begin
								free_map_q[div_idx] <= 1'b1;
								if (used_q != '0) begin
									used_q <= used_q - CNT_W'(1);
								end
								free_q <= free_q + bbpa_pkg::CTR_W'(1);
							end
						end
						state_q <= ST_DONE;
					end
				end

				ST_MUL: begin
					res_boff_q <= bbpa_pkg::OFF_W'(mul_p);
					state_q    <= ST_DONE;
				end

				ST_DONE: begin
					if (out_free) begin
						status_q    <= res_status_q;
						index_q     <= res_idx_q;
						boff_q      <= res_boff_q;
						used_out_q  <= used_q;
						peak_out_q  <= peak_q;
						alloc_out_q <= alloc_q;
						free_out_q  <= free_q;
						fail_out_q  <= fail_q;
						health_q    <= health_d;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot_index   = bbpa_pkg::IDX_OUT_W'(index_q);
	assign block_offset = boff_q;
	assign used_now     = bbpa_pkg::COUNT_W'(used_out_q);
	assign used_peak    = bbpa_pkg::COUNT_W'(peak_out_q);
	assign alloc_total  = alloc_out_q;
	assign free_total   = free_out_q;
	assign fail_total   = fail_out_q;
	assign health       = health_q;

	`BBPA_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= CNT_W'(MAX_BLOCKS))
	`BBPA_ASSERT_IMP(a_peak_ge_used, clk, arst_n, 1'b1, peak_q >= used_q)
	`BBPA_ASSERT_IMP(a_div_done_in_div, clk, arst_n, div_rsp.done, state_q == ST_DIV)
	`BBPA_ASSERT_NXT(a_one_in_flight, clk, arst_n, in_fire, !in_ready)

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	// Opcode 3 has no name in the package; the block must treat it as a no-op.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int POOL_MAX     = 64;
	localparam int SIZE_MAX     = 1024;
	localparam int HOLD_CYCLES  = 400;   // long receiver stall to back up the block
	localparam int STALL_LIMIT  = 4000;  // cycles with no handshake on any channel
	localparam int DRAIN_CYCLES = 80;    // slowest word is a full 64-slot scan
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 100;

	// one result word, field order matches the port list
	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot_index;
		logic [15:0] block_offset;
		logic [6:0]  used_now;
		logic [6:0]  used_peak;
		logic [31:0] alloc_total;
		logic [31:0] free_total;
		logic [31:0] fail_total;
		logic [1:0]  health;
	} pool_result_t;

	// Pool model plus the queue of result words still owed by the block.
	class pool_scoreboard;
		bit [6:0]     count_reg;
		bit [10:0]    size_reg;
		bit [63:0]    free_map;
		bit [5:0]     hint;
		bit [6:0]     used;
		bit [6:0]     peak;
		bit [31:0]    allocs;
		bit [31:0]    frees;
		bit [31:0]    fails;
		pool_result_t due_results[$];
		int           errors;

		function new();
			count_reg = 7'd64;
			size_reg  = 11'd32;
			free_map  = '1;
			hint      = '0;
			used      = '0;
			peak      = '0;
			allocs    = '0;
			frees     = '0;
			fails     = '0;
			errors    = 0;
		endfunction

		function void write_reg(logic idx, bit [10:0] data);
			if (idx == bbpa_pkg::CFG_BLOCK_COUNT) begin
				count_reg = data[6:0];
			end else begin
				size_reg = data;
			end
		endfunction

		// register values outside the legal range are clamped
		function int unsigned pool_blocks();
			if (count_reg == 0)
				return 1;
			if (count_reg > POOL_MAX)
				return POOL_MAX;
			return count_reg;
		endfunction

		function int unsigned block_bytes();
			if (size_reg == 0)
				return 1;
			if (size_reg > SIZE_MAX)
				return SIZE_MAX;
			return size_reg;
		endfunction

		function void note_request(bit [1:0] op, bit [15:0] off);
			pool_result_t r;
			int unsigned  cnt;
			int unsigned  sz;
			int unsigned  start;
			int unsigned  k;
			int unsigned  util;
			bit           found;
			cnt   = pool_blocks();
			sz    = block_bytes();
			r     = '0;
			found = 1'b0;
			case (op)
				bbpa_pkg::OP_ALLOC: begin
					// next-fit: start at the hint (or 0 if the pool shrank under it), wrap
					if (used < cnt) begin
						start = (hint < cnt) ? hint : 0;
						for (int unsigned i = 0; i < cnt && !found; i++) begin
							k = (start + i) % cnt;
							if (free_map[k]) begin
								found        = 1'b1;
								r.slot_index = 6'(k);
							end
						end
					end
					if (found) begin
						free_map[r.slot_index] = 1'b0;
						used++;
						allocs++;
						if (used > peak)
							peak = used;
						hint           = 6'((r.slot_index + 1) % cnt);
						r.block_offset = 16'(r.slot_index * sz);
					end else begin
						r.status = bbpa_pkg::STAT_FULL;
						fails++;
					end
				end
				bbpa_pkg::OP_FREE: begin
					k = off / sz;
					if (k >= cnt || off % sz != 0) begin
						r.status = bbpa_pkg::STAT_INVALID;
					end else begin
						r.slot_index   = 6'(k);
						r.block_offset = 16'(k * sz);
						if (free_map[k]) begin
							r.status = bbpa_pkg::STAT_DOUBLE;
						end else begin
							free_map[k] = 1'b1;
							if (used > 0)
								used--;
							frees++;
						end
					end
				end
				bbpa_pkg::OP_STATS: begin
					allocs = '0;
					frees  = '0;
					fails  = '0;
					peak   = used;
				end
				default: ;
			endcase
			// used can exceed a shrunk count, so util may pass 100
			util          = used * bbpa_pkg::PCT_SCALE / cnt;
			r.health      = (util >= bbpa_pkg::HEALTH_CRIT_PCT) ? bbpa_pkg::HEALTH_CRIT :
			                (util >= bbpa_pkg::HEALTH_WARN_PCT) ? bbpa_pkg::HEALTH_WARN :
			                bbpa_pkg::HEALTH_GOOD;
			r.used_now    = used;
			r.used_peak   = peak;
			r.alloc_total = allocs;
			r.free_total  = frees;
			r.fail_total  = fails;
			due_results.push_back(r);
		endfunction

		function string describe(pool_result_t r);
			return $sformatf({"st=%0d idx=%0d off=%0d used=%0d peak=%0d alloc=%0d ",
				"free=%0d fail=%0d health=%0d"}, r.status, r.slot_index, r.block_offset,
				r.used_now, r.used_peak, r.alloc_total, r.free_total, r.fail_total, r.health);
		endfunction

		function void check_result(pool_result_t got);
			pool_result_t want;
			string        bad;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result word with none outstanding: %s", $time, describe(got));
				return;
			end
			want = due_results.pop_front();
			bad  = "";
			if (got.status != want.status)             bad = {bad, " status"};
			if (got.slot_index != want.slot_index)     bad = {bad, " slot_index"};
			if (got.block_offset != want.block_offset) bad = {bad, " block_offset"};
			if (got.used_now != want.used_now)         bad = {bad, " used_now"};
			if (got.used_peak != want.used_peak)       bad = {bad, " used_peak"};
			if (got.alloc_total != want.alloc_total)   bad = {bad, " alloc_total"};
			if (got.free_total != want.free_total)     bad = {bad, " free_total"};
			if (got.fail_total != want.fail_total)     bad = {bad, " fail_total"};
			if (got.health != want.health)             bad = {bad, " health"};
			if (bad != "") begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: result word wrong in%s", $time, bad);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode       = bbpa_pkg::OP_ALLOC;
	logic [15:0] byte_offset  = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [1:0]  status;
	logic [5:0]  slot_index;
	logic [15:0] block_offset;
	logic [6:0]  used_now;
	logic [6:0]  used_peak;
	logic [31:0] alloc_total;
	logic [31:0] free_total;
	logic [31:0] fail_total;
	logic [1:0]  health;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic        cfg_index    = bbpa_pkg::CFG_BLOCK_COUNT;
	logic [10:0] cfg_data     = '0;

	pool_scoreboard sb;
	bit             steady       = 1'b0;  // no idling on either side while set
	bit             hold_request = 1'b0;  // asks the receiver for one long stall
	bit             hold_done    = 1'b0;  // receiver has taken the hold request
	int             hold_left    = 0;
	int             quiet_cycles = 0;

	// Plan for the first phases; later phases draw their settings at random.
	// Filling at 64 then shrinking to 10 leaves a stale hint and stranded blocks.
	int plan_count[8] = '{64, 10, 64, 1, 0, 127, 20, 64};
	int plan_size[8]  = '{32, 32, 1024, 1, 0, 2047, 100, 1023};
	int plan_alloc[8] = '{90, 50, 30, 60, 60, 85, 70, 40};

	bitmap_block_pool_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.byte_offset  (byte_offset),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot_index   (slot_index),
		.block_offset (block_offset),
		.used_now     (used_now),
		.used_peak    (used_peak),
		.alloc_total  (alloc_total),
		.free_total   (free_total),
		.fail_total   (fail_total),
		.health       (health),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// Receiver: random stalls about 8 percent of the time, none while steady,
	// and one long hold-off on request so the block backs up into in_ready.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 8);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({status, slot_index, block_offset, used_now, used_peak,
				alloc_total, free_total, fail_total, health});
	end

	// watchdog: any accepted word on any channel resets the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("bitmap_block_pool_allocator: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Valid stays high between back-to-back words; it only drops for an idle gap.
	task automatic send_request(bit [1:0] op, bit [15:0] off);
		if (!steady && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while (!steady && $urandom_range(99) < 8);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		byte_offset <= off;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(op, off);
	endtask

	// sender pause: nothing offered until every owed result word is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure_pool(bit [6:0] count, bit [10:0] size);
		cfg_valid <= 1'b1;
		cfg_index <= bbpa_pkg::CFG_BLOCK_COUNT;
		cfg_data  <= {4'b0, count};
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(bbpa_pkg::CFG_BLOCK_COUNT, {4'b0, count});
		cfg_index <= bbpa_pkg::CFG_BLOCK_SIZE;
		cfg_data  <= size;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(bbpa_pkg::CFG_BLOCK_SIZE, size);
		cfg_valid <= 1'b0;
	endtask

	// random block below the active count that is free (or in use)
	function automatic bit pick_block(bit want_free, output int idx);
		int spots[$];
		for (int k = 0; k < sb.pool_blocks(); k++)
			if (sb.free_map[k] == want_free)
				spots.push_back(k);
		idx = 0;
		if (spots.size() == 0)
			return 1'b0;
		idx = spots[$urandom_range(spots.size() - 1)];
		return 1'b1;
	endfunction

	// Mostly well-formed traffic: allocs and frees of live blocks, with some
	// double frees, bad offsets, raw noise, stats clears and the unused opcode.
	task automatic send_random(int alloc_pct);
		int          r;
		int          idx;
		int unsigned cnt;
		int unsigned sz;
		bit [1:0]    op;
		bit [15:0]   off;
		cnt = sb.pool_blocks();
		sz  = sb.block_bytes();
		op  = bbpa_pkg::OP_ALLOC;
		off = 16'($urandom_range(16'hFFFF));
		r   = $urandom_range(99);
		if (r >= alloc_pct) begin
			r = $urandom_range(99);
			if (r < 65) begin
				if (pick_block(1'b0, idx)) begin
					op  = bbpa_pkg::OP_FREE;
					off = 16'(idx * sz);
				end
			end else if (r < 75) begin
				if (pick_block(1'b1, idx)) begin
					op  = bbpa_pkg::OP_FREE;
					off = 16'(idx * sz);
				end
			end else if (r < 83) begin
				op = bbpa_pkg::OP_FREE;
				if (sz > 1 && $urandom_range(1))
					off = 16'($urandom_range(cnt - 1) * sz + $urandom_range(sz - 1, 1));
				else
					off = 16'(cnt * sz + $urandom_range(sz - 1));
			end else if (r < 91) begin
				op = bbpa_pkg::OP_FREE;
			end else if (r < 96) begin
				op = bbpa_pkg::OP_STATS;
			end else begin
				op = OP_UNUSED;
			end
		end
		send_request(op, off);
	endtask

	initial begin
		int count;
		int size;
		int alloc_pct;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset config of 64 blocks of 32 bytes
		send_request(bbpa_pkg::OP_ALLOC, 16'h0000);
		send_request(bbpa_pkg::OP_ALLOC, 16'hFFFF);
		send_request(bbpa_pkg::OP_FREE, 16'h0000);    // ok, block 0
		send_request(bbpa_pkg::OP_FREE, 16'h0000);    // double free
		send_request(bbpa_pkg::OP_FREE, 16'h0021);    // misaligned
		send_request(bbpa_pkg::OP_FREE, 16'h0800);    // one past the last block
		send_request(bbpa_pkg::OP_FREE, 16'hFFFF);    // far out of range
		send_request(bbpa_pkg::OP_FREE, 16'h0020);    // ok, block 1
		send_request(bbpa_pkg::OP_ALLOC, 16'h0000);   // hint is past block 1 -> block 2
		send_request(bbpa_pkg::OP_STATS, 16'h0000);
		send_request(OP_UNUSED, 16'hFFFF);
		send_request(bbpa_pkg::OP_ALLOC, 16'h5555);
		send_request(bbpa_pkg::OP_FREE, 16'h0060);    // block 3
		send_request(bbpa_pkg::OP_FREE, 16'hFFE0);    // aligned but beyond the pool
		send_request(bbpa_pkg::OP_FREE, 16'h07E0);    // last block, still free
		send_request(bbpa_pkg::OP_STATS, 16'hAAAA);

		for (int p = 0; p < PHASES; p++) begin
			if (p < 8) begin
				count     = plan_count[p];
				size      = plan_size[p];
				alloc_pct = plan_alloc[p];
			end else begin
				count     = $urandom_range(127);
				size      = $urandom_range(2047);
				alloc_pct = $urandom_range(90, 30);
			end
			drain_results();
			configure_pool(7'(count), 11'(size));
			steady = (p == 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 0 && n == 50)
					hold_request = 1'b1;
				if (p == 6 && n == 50)
					drain_results();
				send_random(alloc_pct);
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("bitmap_block_pool_allocator: match");
		else
			$display("bitmap_block_pool_allocator: mismatch");
		$finish;
	end

endmodule
